### src/delayed_event_timer_queue_unit_defines.svh
// Assertion macros shared by the RTL of the delayed event timer queue.
`ifndef DELAYED_EVENT_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELAYED_EVENT_TIMER_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DETQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("delayed event timer queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DETQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("delayed event timer queue: next-cycle check failed");

`endif

### src/detq_pkg.sv
`default_nettype none

package detq_pkg;

  // Number of entries in the list.
  localparam int QUEUE_DEPTH = 16;

  // Width of an entry count (0 up to QUEUE_DEPTH) and of a list index.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Interrupt levels that own a pending bit.
  localparam logic [3:0] LEVEL_LOW  = 4'd10;
  localparam logic [3:0] LEVEL_HIGH = 4'd13;

  // Opcodes of an input word.
  localparam logic [1:0] OP_QUEUE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_QUEUED  = 3'd0;
  localparam logic [2:0] KIND_DROPPED = 3'd1;
  localparam logic [2:0] KIND_FIRED   = 3'd2;
  localparam logic [2:0] KIND_NONE    = 3'd3;
  localparam logic [2:0] KIND_IRQ     = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] delay_ticks;
    logic [15:0] event_param;
    logic [3:0]  irq_level;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] fired_param;
    logic [3:0]  fired_level;
    logic [3:0]  pending_irqs;
    logic [4:0]  occupancy;
    logic        last;
  } out_word_t;

  // One pending event as held in a cell.
  typedef struct packed {
    logic [15:0] ticks;
    logic [15:0] param;
    logic [3:0]  level;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;      // write the new event into this cell
    logic mark;      // count down and flag expiry
    logic shift;     // take the neighbor's contents
    logic in_range;  // this cell holds a live entry
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/detq_cell.sv
`default_nettype none

module detq_cell import detq_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    load_entry,
  input  wire entry_t    nbr_entry,
  input  wire logic      nbr_exp,
  output entry_t         cell_entry,
  output logic           cell_exp
);

  entry_t entry_r;
  logic   exp_r;

  // A cell loads a new event, counts down on a tick, or takes its neighbor's
  // entry when the list closes up over an expired one.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= load_entry;
    end else if (ctl.mark) begin
      exp_r         <= ctl.in_range && (entry_r.ticks <= 16'd1);
      entry_r.ticks <= entry_r.ticks - 16'd1;
    end else if (ctl.shift) begin
      entry_r <= nbr_entry;
      exp_r   <= nbr_exp;
    end
  end

  assign cell_entry = entry_r;
  assign cell_exp   = exp_r;

endmodule

`default_nettype wire

### src/delayed_event_timer_queue_unit.sv
`default_nettype none

// Delayed event timer queue. A word is taken when start is high and busy is
// low. Queue, raise and clear words answer one result word on the following
// cycle. A tick first counts every cell down, then adds up the expiry flags,
// group sums first and then their total, and then a pointer walks the row of
// cells, emitting one result word per expired entry while the cells behind
// it shift forward by one. Every result word appears on out_word for exactly
// one cycle with out_strobe high and cannot be held off, so the receiver must
// take it then. The entry stores need no clearing after reset.
module delayed_event_timer_queue_unit import detq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_strobe,
  output out_word_t     out_word
);

`include "delayed_event_timer_queue_unit_defines.svh"

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SUM   = 2'd1;
  localparam logic [1:0] S_TOTAL = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  // Expiry flags are summed in groups of eight, then the groups are added.
  localparam int GRP_N = (QUEUE_DEPTH + 7) / 8;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] fire_left_r, fire_left_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [3:0]       irq_pending_r, irq_pending_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic [3:0]       grp_r [GRP_N];

  logic             do_load, do_mark;
  logic [CNT_W-1:0] fire_total;
  logic [1:0]       lvl_off;
  logic             lvl_ok;
  logic [3:0]       lvl_bit;

  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_exp   [QUEUE_DEPTH];
  logic             shift_en   [QUEUE_DEPTH];
  entry_t           load_entry;
  entry_t           sel_entry;
  logic             sel_exp;
  logic             scan_last;

  assign load_entry = '{ticks: in_word.delay_ticks, param: in_word.event_param,
                        level: in_word.irq_level};

  // Row of cells; each one hands its entry to the cell in front of it.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr_entry;
    logic      nbr_exp;

    assign shift_en[i]  = (state_r == S_SCAN) && sel_exp && (PTR_W'(i) >= ptr_r);
    assign ctl.load     = do_load && (CNT_W'(i) == count_r);
    assign ctl.mark     = do_mark;
    assign ctl.shift    = shift_en[i];
    assign ctl.in_range = CNT_W'(i) < count_r;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr_entry = cell_entry[i+1];
      assign nbr_exp   = cell_exp[i+1];
    end else begin : g_tail
      assign nbr_entry = cell_entry[i];
      assign nbr_exp   = 1'b0;
    end

    detq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_entry (load_entry),
      .nbr_entry  (nbr_entry),
      .nbr_exp    (nbr_exp),
      .cell_entry (cell_entry[i]),
      .cell_exp   (cell_exp[i])
    );
  end

  // Cell under the scan pointer.
  assign sel_entry = cell_entry[ptr_r];
  assign sel_exp   = cell_exp[ptr_r];
  assign scan_last = (fire_left_r == CNT_W'(1));

  // First stage of the expiry count: one partial sum per group of eight.
  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) begin
      logic [3:0] acc;
      acc = 4'd0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < QUEUE_DEPTH) begin
          acc = acc + {3'd0, cell_exp[g*8+k]};
        end
      end
      grp_r[g] <= acc;
    end
  end

  // Second stage: total number of expired entries.
  always_comb begin
    fire_total = '0;
    for (int g = 0; g < GRP_N; g++) begin
      fire_total = fire_total + CNT_W'(grp_r[g]);
    end
  end

  // Pending bit addressed by a raise or clear word.
  assign lvl_ok  = (in_word.irq_level >= LEVEL_LOW) && (in_word.irq_level <= LEVEL_HIGH);
  assign lvl_off = 2'(in_word.irq_level - LEVEL_LOW);
  assign lvl_bit = 4'b0001 << lvl_off;

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    fire_left_nxt   = fire_left_r;
    ptr_nxt         = ptr_r;
    irq_pending_nxt = irq_pending_r;
    out_strobe_nxt  = 1'b0;
    out_word_nxt    = out_word_r;
    do_load         = 1'b0;
    do_mark         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_word_nxt = '{result_kind: KIND_IRQ, fired_param: 16'd0, fired_level: 4'd0,
                           pending_irqs: irq_pending_r, occupancy: 5'(count_r), last: 1'b1};
          unique case (in_word.opcode) inside
            OP_QUEUE: begin
              out_strobe_nxt = 1'b1;
              if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                out_word_nxt.result_kind = KIND_DROPPED;
              end else begin
                do_load                = 1'b1;
                count_nxt              = count_r + CNT_W'(1);
                out_word_nxt.result_kind = KIND_QUEUED;
                out_word_nxt.occupancy   = 5'(count_nxt);
              end
            end
            OP_TICK: begin
              do_mark   = 1'b1;
              state_nxt = S_SUM;
            end
            OP_RAISE, OP_CLEAR: begin
              out_strobe_nxt = 1'b1;
              if (lvl_ok) begin
                irq_pending_nxt = (in_word.opcode == OP_RAISE) ?
                                  (irq_pending_r | lvl_bit) : (irq_pending_r & ~lvl_bit);
              end
              out_word_nxt.pending_irqs = irq_pending_nxt;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        if (fire_total == '0) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{result_kind: KIND_NONE, fired_param: 16'd0, fired_level: 4'd0,
                             pending_irqs: irq_pending_r, occupancy: 5'(count_r),
                             last: 1'b1};
          state_nxt      = S_IDLE;
        end else begin
          count_nxt     = count_r - fire_total;
          fire_left_nxt = fire_total;
          ptr_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sel_exp) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{result_kind: KIND_FIRED, fired_param: sel_entry.param,
                             fired_level: sel_entry.level, pending_irqs: irq_pending_r,
                             occupancy: 5'(count_r), last: scan_last};
          fire_left_nxt  = fire_left_r - CNT_W'(1);
          if (scan_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      fire_left_r   <= '0;
      ptr_r         <= '0;
      irq_pending_r <= 4'd0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      fire_left_r   <= fire_left_nxt;
      ptr_r         <= ptr_nxt;
      irq_pending_r <= irq_pending_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // The scan runs only while expired entries are still to be reported.
  `DETQ_ASSERT_SAME(a_scan_has_work, clk, rst_n, state_r == S_SCAN, fire_left_r != '0)
  // The final word of an input leaves the block idle.
  `DETQ_ASSERT_SAME(a_last_idle, clk, rst_n, out_strobe_r && out_word_r.last,
                    state_r == S_IDLE)
  // The list never reports more entries than it holds.
  `DETQ_ASSERT_SAME(a_occ_bound, clk, rst_n, out_strobe_r,
                    out_word_r.occupancy <= 5'(QUEUE_DEPTH))
  // A tick always goes on to add up the expiry flags.
  `DETQ_ASSERT_NEXT(a_tick_sum, clk, rst_n,
                    start && !busy && (in_word.opcode == OP_TICK), state_r == S_SUM)

endmodule

`default_nettype wire

### tb/tb_delayed_event_timer_queue_unit.sv
`default_nettype none

module tb_delayed_event_timer_queue_unit import detq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 330;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  // Shadow of the event list that predicts every result word and checks the DUT.
  class timer_queue_shadow;
    logic [15:0] ticks_left [QUEUE_DEPTH];
    logic [15:0] params [QUEUE_DEPTH];
    logic [3:0]  levels [QUEUE_DEPTH];
    int unsigned live_count;
    logic [3:0]  irq_bits;
    out_word_t   expected_words [$];
    int unsigned mismatch_count;

    function new();
      live_count = 0;
      irq_bits = '0;
      mismatch_count = 0;
    endfunction

    // Results carry the pending bits and the occupancy after the whole step.
    function void push_result(logic [2:0] kind, logic [15:0] p, logic [3:0] l,
                              logic is_last);
      out_word_t r;
      r.result_kind  = kind;
      r.fired_param  = p;
      r.fired_level  = l;
      r.pending_irqs = irq_bits;
      r.occupancy    = live_count[4:0];
      r.last         = is_last;
      expected_words.push_back(r);
    endfunction

    // Updates the shadow list for an accepted input word.
    function void accept_word(in_word_t w);
      logic [15:0] fired_p [QUEUE_DEPTH];
      logic [3:0]  fired_l [QUEUE_DEPTH];
      int unsigned nfired;
      int unsigned keep;
      logic [3:0]  bit_mask;
      case (w.opcode)
        OP_QUEUE: begin
          if (live_count >= QUEUE_DEPTH) begin
            push_result(KIND_DROPPED, '0, '0, 1'b1);
          end else begin
            ticks_left[live_count] = w.delay_ticks;
            params[live_count]     = w.event_param;
            levels[live_count]     = w.irq_level;
            live_count++;
            push_result(KIND_QUEUED, '0, '0, 1'b1);
          end
        end
        OP_TICK: begin
          // Expired entries leave in list order; survivors close up.
          nfired = 0;
          keep = 0;
          for (int i = 0; i < live_count; i++) begin
            if (ticks_left[i] <= 16'd1) begin
              fired_p[nfired] = params[i];
              fired_l[nfired] = levels[i];
              nfired++;
            end else begin
              ticks_left[keep] = ticks_left[i] - 16'd1;
              params[keep]     = params[i];
              levels[keep]     = levels[i];
              keep++;
            end
          end
          live_count = keep;
          if (nfired == 0) begin
            push_result(KIND_NONE, '0, '0, 1'b1);
          end else begin
            for (int j = 0; j < nfired; j++) begin
              push_result(KIND_FIRED, fired_p[j], fired_l[j], j == nfired - 1);
            end
          end
        end
        default: begin
          // Only levels 10 to 13 own a pending bit; others are answered anyway.
          if (w.irq_level >= LEVEL_LOW && w.irq_level <= LEVEL_HIGH) begin
            bit_mask = 4'b0001 << (w.irq_level - LEVEL_LOW);
            if (w.opcode == OP_RAISE) begin
              irq_bits = irq_bits | bit_mask;
            end else begin
              irq_bits = irq_bits & ~bit_mask;
            end
          end
          push_result(KIND_IRQ, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatch_count++;
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // Compares a result word with the oldest expectation.
    function void check_result(out_word_t r);
      out_word_t want;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $error("result word with no expectation pending: %h", r);
        return;
      end
      want = expected_words.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(r.result_kind));
      compare_field("fired_param", 32'(want.fired_param), 32'(r.fired_param));
      compare_field("fired_level", 32'(want.fired_level), 32'(r.fired_level));
      compare_field("pending_irqs", 32'(want.pending_irqs), 32'(r.pending_irqs));
      compare_field("occupancy", 32'(want.occupancy), 32'(r.occupancy));
      compare_field("last", 32'(want.last), 32'(r.last));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  timer_queue_shadow shadow = new();
  int unsigned items_sent;
  int unsigned stall_cycles;
  bit          gaps_on;
  bit          drained;

  delayed_event_timer_queue_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results are checked before the input accepted at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        shadow.check_result(out_word);
      end
      if (start && !busy) begin
        shadow.accept_word(in_word);
      end
    end
  end

  // The run ends if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic in_word_t make_word(logic [1:0] op, logic [15:0] d, logic [15:0] p,
                                         logic [3:0] l);
    in_word_t w;
    w.opcode      = op;
    w.delay_ticks = d;
    w.event_param = p;
    w.irq_level   = l;
    return w;
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Presents one word and holds it until the block takes it; start stays high
  // so that a following word can go out back to back.
  task automatic send_word(in_word_t w);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      idle_cycles($urandom_range(1, 11));
    end
  endtask

  // Holds the sender off until every expected result word has come.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (shadow.expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic send_irq_word(logic [1:0] op, logic [3:0] l);
    send_word(make_word(op, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), l));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    items_sent = 0;
    stall_cycles = 0;
    gaps_on = 1'b1;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a zero delay, survivors ahead of expiries, an empty tick,
    // and raise and clear on levels inside and outside 10 to 13.
    send_word(make_word(OP_QUEUE, 16'd0, 16'hFFFF, 4'hF));
    send_word(make_word(OP_QUEUE, 16'd3, 16'h0000, 4'h0));
    send_word(make_word(OP_QUEUE, 16'd1, 16'hA5A5, 4'd12));
    send_word(make_word(OP_QUEUE, 16'd2, 16'h5A5A, 4'd10));
    repeat (4) send_word(make_word(OP_TICK, 16'hFFFF, 16'hFFFF, 4'hF));
    send_irq_word(OP_RAISE, 4'd10);
    send_irq_word(OP_RAISE, 4'd13);
    send_irq_word(OP_RAISE, 4'd9);
    send_irq_word(OP_RAISE, 4'd14);
    send_irq_word(OP_RAISE, 4'd15);
    send_irq_word(OP_RAISE, 4'd0);
    send_irq_word(OP_RAISE, 4'd11);
    send_irq_word(OP_CLEAR, 4'd13);
    send_irq_word(OP_CLEAR, 4'd9);
    send_irq_word(OP_CLEAR, 4'd10);
    send_irq_word(OP_CLEAR, 4'd15);
    send_irq_word(OP_RAISE, 4'd12);

    // Random: mostly short delays so that the list churns, fills and empties.
    while (items_sent < ITEM_TARGET - 20) begin
      gaps_on = (items_sent < ITEM_TARGET - 60) && ($urandom_range(0, 3) != 0);
      if (!drained && items_sent >= ITEM_TARGET / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 6)) begin
            send_word(make_word(OP_QUEUE, 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15))));
          end
        end
        4, 5: begin
          repeat ($urandom_range(1, 4)) begin
            send_word(make_word(OP_TICK, 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15))));
          end
        end
        6: begin
          repeat ($urandom_range(1, 4)) begin
            send_irq_word($urandom_range(0, 1) ? OP_RAISE : OP_CLEAR,
                          4'($urandom_range(0, 1) ? $urandom_range(10, 13)
                                                  : $urandom_range(0, 15)));
          end
        end
        7: begin
          // Overfill with words about to expire, then flush them in one tick.
          repeat ($urandom_range(17, 20)) begin
            send_word(make_word(OP_QUEUE, 16'($urandom_range(0, 1)),
                                16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15))));
          end
          send_word(make_word(OP_TICK, '0, '0, '0));
        end
        8: begin
          repeat ($urandom_range(1, 3)) begin
            send_word(make_word(2'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15))));
          end
        end
        default: begin
          repeat ($urandom_range(5, 8)) begin
            send_word(make_word(OP_TICK, '0, '0, '0));
          end
        end
      endcase
    end

    // Closing part without gaps: a maximal delay and full-range random delays.
    gaps_on = 1'b0;
    send_word(make_word(OP_QUEUE, 16'hFFFF, 16'($urandom_range(0, 65535)),
                        4'($urandom_range(0, 15))));
    repeat (6) begin
      send_word(make_word(OP_QUEUE, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15))));
    end
    repeat (6) send_word(make_word(OP_TICK, '0, '0, '0));
    repeat (4) send_irq_word(2'($urandom_range(2, 3)), 4'($urandom_range(0, 15)));

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
